// ----- src/u8u16_pkg.sv -----
package u8u16_pkg;

    // Number of bytes an unfinished sequence may occupy.
    localparam int HOLD_DEPTH = 4;
    localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);

    // Code point and code unit constants.
    localparam logic [15:0] REPLACEMENT_UNIT = 16'hFFFD;
    localparam logic [20:0] SURR_FIRST       = 21'h00D800;
    localparam logic [20:0] SURR_LAST        = 21'h00DFFF;
    localparam logic [20:0] BMP_LAST         = 21'h00FFFF;
    localparam logic [20:0] CP_LAST          = 21'h10FFFF;
    localparam logic [20:0] SUPP_BASE        = 21'h010000;
    localparam logic [5:0]  HIGH_SURR_TAG    = 6'b110110;
    localparam logic [5:0]  LOW_SURR_TAG     = 6'b110111;

    // Minimum code point for each multi-byte length.
    localparam logic [20:0] MIN_TWO_BYTE   = 21'h000080;
    localparam logic [20:0] MIN_THREE_BYTE = 21'h000800;
    localparam logic [20:0] MIN_FOUR_BYTE  = 21'h010000;

    // Number of continuation bytes that follow a lead byte.
    typedef enum logic [1:0] {
        EXTRA_NONE  = 2'd0,
        EXTRA_ONE   = 2'd1,
        EXTRA_TWO   = 2'd2,
        EXTRA_THREE = 2'd3
    } extra_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LOW
    } state_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_end;
    } byte_req_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        run_last;
        logic        string_last;
    } unit_req_t;

endpackage

// ----- src/utf8_to_utf16_decoder_top.sv -----
// UTF-8 to UTF-16 transcoder.
// The byte channel (byte_valid, byte_ready, byte_req) takes one UTF-8 byte per
// request together with a flag that marks the last byte of a string. The unit
// channel (unit_valid, unit_ready, unit_req) returns UTF-16 code units, with
// run_last on the final unit caused by a byte and string_last on the final
// unit of a string. Malformed input gives U+FFFD; characters above U+FFFF
// come out as a surrogate pair.
// A byte is taken only while the sequencer is idle. It then examines the
// held sequence once per cycle while the output is not stalled, emitting at
// most one unit per cycle: it accepts the byte, takes a step per decoded or
// rejected sequence (up to four after a bad continuation), a step for a low
// surrogate, and a step to close the run. The last unit of a byte appears on
// the output register in the cycle after it is known to be last. A byte that
// only extends an unfinished sequence gives no unit; it is accepted, then its run closes.
// Reset empties the held sequence and clears the sequencer and the output
// valid flag. While the receiver holds unit_ready low, the sequencer stops at
// its next unit and byte_ready stays low until that byte's run has been
// passed to the output register.
module utf8_to_utf16_decoder_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_ready,
    input  u8u16_pkg::byte_req_t  byte_req,
    output logic                  unit_valid,
    input  logic                  unit_ready,
    output u8u16_pkg::unit_req_t  unit_req
);
    import u8u16_pkg::*;

    state_t           state_reg, state_next;
    logic [7:0]       held_reg [HOLD_DEPTH];
    logic [7:0]       held_next [HOLD_DEPTH];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             end_reg, end_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [15:0]      pend_unit_reg, pend_unit_next;
    logic [15:0]      low_reg, low_next;
    logic             out_valid_reg, out_valid_next;
    unit_req_t        out_reg, out_next;

    // Decoder of the sequence at the head of the held bytes.
    logic [7:0]       lead;
    extra_t           extra;
    logic             bad_lead;
    logic             cont_ok;
    logic [CNT_W-1:0] need;
    logic             incomplete;
    logic [20:0]      cp;
    logic [19:0]      supp_ofs;
    logic [15:0]      dec_unit;
    logic [15:0]      dec_low;
    logic             dec_pair;
    logic [CNT_W-1:0] dec_drop;

    // Sequencer helpers.
    logic             out_free;
    logic             can_go;
    logic [CNT_W-1:0] drop_cnt;
    logic [CNT_W-1:0] shift_idx;

    // Classify the lead byte and assemble the code point.
    always_comb
    begin
        lead     = held_reg[0];
        bad_lead = 1'b0;
        extra    = EXTRA_NONE;
        priority if (lead[7] == 1'b0)
        begin
            extra = EXTRA_NONE;
        end
        else if (lead[7:5] == 3'b110)
        begin
            extra = EXTRA_ONE;
        end
        else if (lead[7:4] == 4'b1110)
        begin
            extra = EXTRA_TWO;
        end
        else if (lead[7:3] == 5'b11110)
        begin
            extra = EXTRA_THREE;
        end
        else
        begin
            bad_lead = 1'b1;
        end

        need       = CNT_W'(extra) + CNT_W'(1);
        incomplete = !bad_lead && (cnt_reg < need);

        cont_ok = 1'b1;
        for (int k = 1; k < HOLD_DEPTH; k++)
        begin
            if (k <= int'(extra) && held_reg[k][7:6] != 2'b10)
            begin
                cont_ok = 1'b0;
            end
        end

        unique case (extra)
            EXTRA_NONE:  cp = {13'd0, lead};
            EXTRA_ONE:   cp = {10'd0, lead[4:0], held_reg[1][5:0]};
            EXTRA_TWO:   cp = {5'd0, lead[3:0], held_reg[1][5:0], held_reg[2][5:0]};
            EXTRA_THREE: cp = {lead[2:0], held_reg[1][5:0], held_reg[2][5:0],
                               held_reg[3][5:0]};
            default:     cp = '0;
        endcase

        supp_ofs = 20'(cp - SUPP_BASE);
        dec_low  = {LOW_SURR_TAG, supp_ofs[9:0]};
        dec_pair = 1'b0;
        dec_drop = need;
        dec_unit = REPLACEMENT_UNIT;

        priority if (bad_lead || !cont_ok)
        begin
            dec_drop = CNT_W'(1);
        end
        else if ((extra == EXTRA_ONE && cp < MIN_TWO_BYTE) ||
                 (extra == EXTRA_TWO && cp < MIN_THREE_BYTE) ||
                 (extra == EXTRA_THREE && cp < MIN_FOUR_BYTE) ||
                 (cp >= SURR_FIRST && cp <= SURR_LAST) || cp > CP_LAST)
        begin
            dec_unit = REPLACEMENT_UNIT;
        end
        else if (cp <= BMP_LAST)
        begin
            dec_unit = cp[15:0];
        end
        else
        begin
            dec_unit = {HIGH_SURR_TAG, supp_ofs[19:10]};
            dec_pair = 1'b1;
        end
    end

    // Sequencer: one head sequence or one surrogate half per cycle unless the output stalls. The newest
    // unit waits in the pending register until it is known whether it is last.
    always_comb
    begin
        state_next      = state_reg;
        held_next       = held_reg;
        cnt_next        = cnt_reg;
        end_next        = end_reg;
        pend_valid_next = pend_valid_reg;
        pend_unit_next  = pend_unit_reg;
        low_next        = low_reg;
        out_valid_next  = out_valid_reg && !unit_ready;
        out_next        = out_reg;
        out_free        = !out_valid_reg || unit_ready;
        can_go          = !pend_valid_reg || out_free;
        byte_ready      = (state_reg == ST_IDLE);
        drop_cnt        = '0;
        shift_idx       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (byte_valid)
                begin
                    held_next[cnt_reg[1:0]] = byte_req.in_byte;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    end_next   = byte_req.string_end;
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                if (can_go)
                begin
                    if (cnt_reg == '0 || (incomplete && !end_reg))
                    begin
                        // Run is over: release the pending unit as the last one.
                        if (pend_valid_reg)
                        begin
                            out_valid_next      = 1'b1;
                            out_next.code_unit  = pend_unit_reg;
                            out_next.run_last   = 1'b1;
                            out_next.string_last = end_reg;
                        end
                        pend_valid_next = 1'b0;
                        if (end_reg)
                        begin
                            cnt_next = '0;
                        end
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next       = 1'b1;
                            out_next.code_unit   = pend_unit_reg;
                            out_next.run_last    = 1'b0;
                            out_next.string_last = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        if (incomplete)
                        begin
                            // Sequence cut off by the end of the string.
                            pend_unit_next = REPLACEMENT_UNIT;
                            cnt_next       = '0;
                        end
                        else
                        begin
                            pend_unit_next = dec_unit;
                            low_next       = dec_low;
                            drop_cnt       = dec_drop;
                            cnt_next       = cnt_reg - drop_cnt;
                            for (int i = 0; i < HOLD_DEPTH; i++)
                            begin
                                shift_idx = CNT_W'(i) + drop_cnt;
                                if (shift_idx < CNT_W'(HOLD_DEPTH))
                                begin
                                    held_next[i] = held_reg[shift_idx[1:0]];
                                end
                            end
                            if (dec_pair)
                            begin
                                state_next = ST_LOW;
                            end
                        end
                    end
                end
            end

            ST_LOW:
            begin
                // Low surrogate of a pair; the high half is pending.
                if (can_go)
                begin
                    out_valid_next       = 1'b1;
                    out_next.code_unit   = pend_unit_reg;
                    out_next.run_last    = 1'b0;
                    out_next.string_last = 1'b0;
                    pend_valid_next      = 1'b1;
                    pend_unit_next       = low_reg;
                    state_next           = ST_DECODE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            end_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            end_reg        <= end_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        held_reg      <= held_next;
        pend_unit_reg <= pend_unit_next;
        low_reg       <= low_next;
        out_reg       <= out_next;
    end

    assign unit_valid = out_valid_reg;
    assign unit_req   = out_reg;

`ifndef SYNTHESIS
    // Between bytes at most three bytes of a sequence are held.
    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> cnt_reg < CNT_W'(HOLD_DEPTH))
        else $error("held byte count too large while idle");

    // A new byte is never taken while a unit of the previous run is pending.
    a_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        byte_ready |-> !pend_valid_reg)
        else $error("byte accepted with a pending unit");

    // An accepted byte is always decoded in the next cycle.
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_ready |=> state_reg == ST_DECODE)
        else $error("accepted byte not decoded");

    // The last unit of a string is also the last unit of its byte.
    a_string_run: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid && unit_req.string_last |-> unit_req.run_last)
        else $error("string_last without run_last");

    // Nothing is held once a string has ended.
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE && end_reg |-> cnt_reg == '0)
        else $error("bytes held after end of string");
`endif

endmodule
